// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the ring FIFO block.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rfs_pkg.sv =====
// Shared types and codes for the ring FIFO with search.
// No dependencies; used by rfs_ctrl and ring_fifo_with_search_core.
`timescale 1ns / 1ps

package rfs_pkg;

   localparam int DATA_W   = 32;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_ENQ  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DEQ  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SRCH = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DEQ,
      S_SCAN,
      S_DONE
   } state_type;

endpackage

// ===== rtl/rfs_mem.sv =====
// Slot storage: one write port, one read port, registered read data.
// Depends on nothing else.
`timescale 1ns / 1ps

module rfs_mem #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rfs_ctrl.sv =====
// Sequencer for the ring FIFO: pointers, count, slot scan and result register.
// Depends on rfs_pkg and assert_macros.svh; drives the port of rfs_mem.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rfs_ctrl #(
   parameter int CAPACITY = 64,
   parameter int PTR_W    = 6,
   parameter int CNT_W    = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rfs_pkg::FUNC_W-1:0]    req_func,
   input  logic [rfs_pkg::DATA_W-1:0]    req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rfs_pkg::STATUS_W-1:0]  rsp_status,
   output logic [rfs_pkg::DATA_W-1:0]    rsp_data,
   output logic [PTR_W-1:0]              rsp_pos,
   output logic                          mem_wr_en,
   output logic [PTR_W-1:0]              mem_wr_addr,
   output logic [rfs_pkg::DATA_W-1:0]    mem_wr_data,
   output logic                          mem_rd_en,
   output logic [PTR_W-1:0]              mem_rd_addr,
   input  logic [rfs_pkg::DATA_W-1:0]    mem_rd_data
);

   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CAPACITY);

   rfs_pkg::state_type state_ff, state_in;

   logic [PTR_W-1:0]             head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [PTR_W-1:0]             scan_slot_ff, scan_slot_in;
   logic [CNT_W-1:0]             scan_left_ff, scan_left_in;
   logic [rfs_pkg::DATA_W-1:0]   key_ff, key_in;
   logic [rfs_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [rfs_pkg::DATA_W-1:0]   res_data_ff, res_data_in;
   logic [PTR_W-1:0]             res_pos_ff, res_pos_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [rfs_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [rfs_pkg::DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [PTR_W-1:0]             rsp_pos_ff, rsp_pos_in;

   logic [PTR_W-1:0] head_nxt, tail_nxt, scan_nxt;
   logic             req_xfer, out_free, is_empty, is_full, hit;

   assign head_nxt = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
   assign tail_nxt = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
   assign scan_nxt = (scan_slot_ff == LAST_SLOT) ? '0 : scan_slot_ff + 1'b1;

   assign req_ready = (state_ff == rfs_pkg::S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == FULL_CNT);
   assign hit       = (mem_rd_data == key_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rfs_pkg::S_IDLE: begin
            if (req_xfer) begin
               if (req_func == rfs_pkg::FUNC_DEQ && !is_empty) begin
                  state_in = rfs_pkg::S_DEQ;
               end else if (req_func == rfs_pkg::FUNC_SRCH && !is_empty) begin
                  state_in = rfs_pkg::S_SCAN;
               end else begin
                  state_in = rfs_pkg::S_DONE;
               end
            end
         end
         rfs_pkg::S_DEQ: begin
            state_in = rfs_pkg::S_DONE;
         end
         rfs_pkg::S_SCAN: begin
            if (hit || scan_left_ff == CNT_W'(1)) begin
               state_in = rfs_pkg::S_DONE;
            end
         end
         rfs_pkg::S_DONE: begin
            if (out_free) begin
               state_in = rfs_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rfs_pkg::S_IDLE;
         end
      endcase
   end

   // datapath and memory port
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      scan_slot_in  = scan_slot_ff;
      scan_left_in  = scan_left_ff;
      key_in        = key_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      res_pos_in    = res_pos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_pos_in    = rsp_pos_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = tail_ff;
      mem_wr_data   = req_value;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = head_ff;
      case (state_ff)
         rfs_pkg::S_IDLE: begin
            if (req_xfer) begin
               key_in        = req_value;
               res_status_in = rfs_pkg::ST_OK;
               res_data_in   = '0;
               res_pos_in    = '0;
               case (req_func)
                  rfs_pkg::FUNC_ENQ: begin
                     if (is_full) begin
                        res_status_in = rfs_pkg::ST_FULL;
                     end else begin
                        mem_wr_en = 1'b1;
                        tail_in   = tail_nxt;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  rfs_pkg::FUNC_DEQ: begin
                     if (is_empty) begin
                        res_status_in = rfs_pkg::ST_EMPTY;
                     end else begin
                        mem_rd_en = 1'b1;
                     end
                  end
                  rfs_pkg::FUNC_SRCH: begin
                     if (is_empty) begin
                        res_status_in = rfs_pkg::ST_NOTFOUND;
                     end else begin
                        mem_rd_en    = 1'b1;
                        scan_slot_in = head_ff;
                        scan_left_in = count_ff;
                     end
                  end
                  default: begin
                     res_status_in = rfs_pkg::ST_OK;
                  end
               endcase
            end
         end
         rfs_pkg::S_DEQ: begin
            res_data_in = mem_rd_data;
            head_in     = head_nxt;
            count_in    = count_ff - 1'b1;
         end
         rfs_pkg::S_SCAN: begin
            if (hit) begin
               res_pos_in = scan_slot_ff;
            end else if (scan_left_ff == CNT_W'(1)) begin
               res_status_in = rfs_pkg::ST_NOTFOUND;
            end else begin
               mem_rd_en    = 1'b1;
               mem_rd_addr  = scan_nxt;
               scan_slot_in = scan_nxt;
               scan_left_in = scan_left_ff - 1'b1;
            end
         end
         rfs_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_data_in   = res_data_ff;
               rsp_pos_in    = res_pos_ff;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_ready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rfs_pkg::S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_slot_ff  <= scan_slot_in;
      scan_left_ff  <= scan_left_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      res_pos_ff    <= res_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_pos_ff    <= rsp_pos_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_pos    = rsp_pos_ff;

   `ASSERT_ALWAYS(a_count_bound, count_ff <= FULL_CNT, "occupancy above capacity")
   `ASSERT_ALWAYS(a_ptr_meet, (count_ff != '0 && count_ff != FULL_CNT) || head_ff == tail_ff, "head and tail apart while empty or full")
   `ASSERT_NEXT(a_busy_after_req, req_xfer, state_ff != rfs_pkg::S_IDLE, "idle right after a request transfer")
   `ASSERT_NEXT(a_deq_read, req_xfer && req_func == rfs_pkg::FUNC_DEQ && !is_empty, state_ff == rfs_pkg::S_DEQ && count_ff == $past(count_ff) - 1'b0, "dequeue did not issue its slot read")

endmodule

// ===== rtl/ring_fifo_with_search_core.sv =====
// Top level of the ring FIFO with search: stream ports around rfs_ctrl and rfs_mem.
// Depends on rfs_pkg, rfs_ctrl and rfs_mem.
`timescale 1ns / 1ps

// Circular FIFO of CAPACITY signed 32-bit words with enqueue, dequeue and
// linear search from head to tail. Every request transfer yields exactly one
// response transfer. One request is in work at a time; a finished response
// waits in an output register while the next request is taken. A search
// reads the occupied slots from the head one after another until a hit, at
// most CAPACITY of them, since the single read port of the slot memory
// delivers one stored word per cycle. Slot contents are not cleared at reset;
// only occupied slots are ever read.

module ring_fifo_with_search_core #(
   parameter int CAPACITY = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // [31:0] value
   input  logic [rfs_pkg::DATA_W-1:0]             req_tdata,
   // [1:0] func
   input  logic [rfs_pkg::FUNC_W-1:0]             req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [31:0] data, [32+PTR_W-1:32] position, zero fill to whole bytes
   output logic [((rfs_pkg::DATA_W + $clog2(CAPACITY) + 7) / 8) * 8 - 1:0] rsp_tdata,
   // [1:0] status
   output logic [rfs_pkg::STATUS_W-1:0]           rsp_tuser
);

   localparam int PTR_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int RSP_W = ((rfs_pkg::DATA_W + PTR_W + 7) / 8) * 8;

   logic                         mem_wr_en, mem_rd_en;
   logic [PTR_W-1:0]             mem_wr_addr, mem_rd_addr;
   logic [rfs_pkg::DATA_W-1:0]   mem_wr_data, mem_rd_data;
   logic [rfs_pkg::DATA_W-1:0]   rsp_data;
   logic [PTR_W-1:0]             rsp_pos;

   rfs_ctrl #(
      .CAPACITY (CAPACITY),
      .PTR_W    (PTR_W),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_func    (req_tuser),
      .req_value   (req_tdata),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_status  (rsp_tuser),
      .rsp_data    (rsp_data),
      .rsp_pos     (rsp_pos),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   rfs_mem #(
      .DEPTH  (CAPACITY),
      .ADDR_W (PTR_W),
      .DATA_W (rfs_pkg::DATA_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_tdata = RSP_W'({rsp_pos, rsp_data});

endmodule

// ===== test/ring_fifo_with_search_core_tb.sv =====
// Testbench for ring_fifo_with_search_core: enqueue, dequeue and search over stream ports,
// checked transfer by transfer against a behavioral FIFO predictor kept in this file.
// Depends on rfs_pkg and the RTL of ring_fifo_with_search_core.
`timescale 1ns / 1ps

module ring_fifo_with_search_core_tb;

   localparam int CAPACITY = 64;
   localparam int PTR_W = $clog2(CAPACITY);
   localparam int RSP_W = ((rfs_pkg::DATA_W + PTR_W + 7) / 8) * 8;
   localparam logic [rfs_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int GAP_MAX = 40;
   localparam int DRAIN_CYCLES = CAPACITY + 16;
   localparam int PHASE_ITEMS = 350;

   typedef struct packed {
      logic [rfs_pkg::STATUS_W-1:0] status;
      logic [rfs_pkg::DATA_W-1:0]   data;
      logic [PTR_W-1:0]             position;
   } fifo_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [rfs_pkg::DATA_W-1:0] req_tdata = '0;
   logic [rfs_pkg::FUNC_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [rfs_pkg::STATUS_W-1:0] rsp_tuser;

   logic [rfs_pkg::DATA_W-1:0] fifo_slots [CAPACITY];
   logic [PTR_W-1:0] fifo_head = '0;
   logic [PTR_W-1:0] fifo_tail = '0;
   int fifo_count = 0;
   fifo_rsp_type expected_rsp_q [$];
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   ring_fifo_with_search_core #(
      .CAPACITY(CAPACITY)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [PTR_W-1:0] next_slot_index(input logic [PTR_W-1:0] s);
      return (s == CAPACITY - 1) ? '0 : s + 1'b1;
   endfunction

   function automatic fifo_rsp_type predict_fifo_op(
      input logic [rfs_pkg::FUNC_W-1:0] func,
      input logic [rfs_pkg::DATA_W-1:0] value);
      fifo_rsp_type r;
      logic [PTR_W-1:0] s;
      r = '0;
      case (func)
         rfs_pkg::FUNC_ENQ: begin
            if (fifo_count >= CAPACITY) begin
               r.status = rfs_pkg::ST_FULL;
            end else begin
               fifo_slots[fifo_tail] = value;
               fifo_tail = next_slot_index(fifo_tail);
               fifo_count++;
            end
         end
         rfs_pkg::FUNC_DEQ: begin
            if (fifo_count == 0) begin
               r.status = rfs_pkg::ST_EMPTY;
            end else begin
               r.data = fifo_slots[fifo_head];
               fifo_head = next_slot_index(fifo_head);
               fifo_count--;
            end
         end
         rfs_pkg::FUNC_SRCH: begin
            r.status = rfs_pkg::ST_NOTFOUND;
            s = fifo_head;
            for (int i = 0; i < fifo_count; i++) begin
               if (fifo_slots[s] == value) begin
                  r.status = rfs_pkg::ST_OK;
                  r.position = s;
                  break;
               end
               s = next_slot_index(s);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [rfs_pkg::DATA_W-1:0] stored_word(input int age);
      return fifo_slots[PTR_W'((fifo_head + age) % CAPACITY)];
   endfunction

   function automatic logic [rfs_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         4, 5: return $urandom_range(7);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [rfs_pkg::DATA_W-1:0] pick_key();
      logic [rfs_pkg::DATA_W-1:0] w;
      if (fifo_count > 0 && $urandom_range(99) < 70) begin
         w = stored_word($urandom_range(fifo_count - 1));
         // near miss: one bit off a stored word
         if ($urandom_range(3) == 0)
            w[$urandom_range(rfs_pkg::DATA_W - 1)] ^= 1'b1;
         return w;
      end
      return pick_value();
   endfunction

   // Called at a rising edge; returns at the rising edge of the transfer.
   task automatic send_item(input logic [rfs_pkg::FUNC_W-1:0] func,
                            input logic [rfs_pkg::DATA_W-1:0] value);
      int gap;
      gap = 0;
      while (gap < GAP_MAX && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      req_tuser <= func;
      do @(negedge clock); while (req_tready !== 1'b1);
      expected_rsp_q.push_back(predict_fifo_op(func, value));
      @(posedge clock);
   endtask

   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      while (expected_rsp_q.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   always @(negedge clock) begin
      fifo_rsp_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_rsp_q.size() == 0) begin
            $error("response transfer with nothing expected");
            error_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d actual %0d", want.status, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[rfs_pkg::DATA_W-1:0] !== want.data) begin
               $error("data: expected %08h actual %08h", want.data,
                      rsp_tdata[rfs_pkg::DATA_W-1:0]);
               error_count++;
            end
            if (rsp_tdata[rfs_pkg::DATA_W +: PTR_W] !== want.position) begin
               $error("position: expected %0d actual %0d", want.position,
                      rsp_tdata[rfs_pkg::DATA_W +: PTR_W]);
               error_count++;
            end
         end
      end
   end

   task automatic test_directed();
      send_item(rfs_pkg::FUNC_DEQ, 32'h1234_5678);
      send_item(rfs_pkg::FUNC_SRCH, 32'h0000_0000);
      send_item(FUNC_UNUSED, 32'hFFFF_FFFF);
      send_item(rfs_pkg::FUNC_ENQ, 32'h8000_0000);
      send_item(rfs_pkg::FUNC_ENQ, 32'h7FFF_FFFF);
      send_item(rfs_pkg::FUNC_ENQ, 32'h0000_0000);
      send_item(rfs_pkg::FUNC_ENQ, 32'hFFFF_FFFF);
      send_item(rfs_pkg::FUNC_ENQ, 32'hAAAA_AAAA);
      send_item(rfs_pkg::FUNC_ENQ, 32'h5555_5555);
      send_item(rfs_pkg::FUNC_ENQ, 32'h7FFF_FFFF);
      send_item(rfs_pkg::FUNC_SRCH, 32'h7FFF_FFFF);
      send_item(rfs_pkg::FUNC_SRCH, 32'hFFFF_FFFF);
      send_item(rfs_pkg::FUNC_SRCH, 32'h7FFF_FFFE);
      send_item(rfs_pkg::FUNC_SRCH, 32'h8000_0000);
      send_item(rfs_pkg::FUNC_SRCH, 32'h5555_5555);
      send_item(FUNC_UNUSED, 32'h0000_0000);
      repeat (7) send_item(rfs_pkg::FUNC_DEQ, $urandom);
      send_item(rfs_pkg::FUNC_DEQ, 32'h0000_0000);
      send_item(rfs_pkg::FUNC_SRCH, 32'h5555_5555);
   endtask

   task automatic test_full_and_wrap();
      while (fifo_count < CAPACITY)
         send_item(rfs_pkg::FUNC_ENQ, pick_value());
      send_item(rfs_pkg::FUNC_ENQ, 32'h7FFF_FFFF);
      send_item(rfs_pkg::FUNC_ENQ, $urandom);
      send_item(rfs_pkg::FUNC_SRCH, stored_word(CAPACITY - 1));
      send_item(rfs_pkg::FUNC_SRCH, stored_word(0));
      send_item(rfs_pkg::FUNC_SRCH, ~stored_word(CAPACITY - 1));
      repeat (20) send_item(rfs_pkg::FUNC_DEQ, $urandom);
      repeat (20) send_item(rfs_pkg::FUNC_ENQ, $urandom);
      send_item(rfs_pkg::FUNC_SRCH, stored_word(CAPACITY - 1));
      send_item(rfs_pkg::FUNC_SRCH, stored_word(CAPACITY - 25));
      send_item(rfs_pkg::FUNC_ENQ, $urandom);
      while (fifo_count > 0)
         send_item(rfs_pkg::FUNC_DEQ, $urandom);
      send_item(rfs_pkg::FUNC_DEQ, $urandom);
      send_item(rfs_pkg::FUNC_SRCH, $urandom);
   endtask

   task automatic test_random(input int n_items);
      int target;
      int r;
      int enq_pct;
      target = $urandom_range(CAPACITY);
      repeat (n_items) begin
         if ($urandom_range(31) == 0) begin
            case ($urandom_range(3))
               0: target = 0;
               1: target = CAPACITY;
               default: target = $urandom_range(CAPACITY);
            endcase
         end
         r = $urandom_range(99);
         enq_pct = (fifo_count < target) ? 85 : (fifo_count > target) ? 15 : 50;
         if (r < 3)
            send_item(FUNC_UNUSED, $urandom);
         else if (r < 28)
            send_item(rfs_pkg::FUNC_SRCH, pick_key());
         else if ($urandom_range(99) < enq_pct)
            send_item(rfs_pkg::FUNC_ENQ, pick_value());
         else
            send_item(rfs_pkg::FUNC_DEQ, $urandom);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      wait_for_responses();
      test_full_and_wrap();
      wait_for_responses();

      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_random(PHASE_ITEMS);
      wait_for_responses();

      send_idle_pct = 84;
      recv_stall_pct = 0;
      test_random(PHASE_ITEMS);
      wait_for_responses();

      send_idle_pct = 0;
      recv_stall_pct = 84;
      test_random(PHASE_ITEMS);
      wait_for_responses();

      send_idle_pct = 24;
      recv_stall_pct = 24;
      test_random(PHASE_ITEMS);
      wait_for_responses();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_rsp_q.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #6_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
